/* rtl/core/wfts_pkg.sv */
// shared constants and types for the windowed frame time statistics block
`default_nettype none
package wfts_pkg;

  localparam int unsigned TS_W       = 48;
  localparam int unsigned WARMUP_W   = 16;
  localparam int unsigned WINDOW_W   = 9;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned MEDIAN_W   = 33;

  // floor(n / 20) as (n * P95_RECIP) >> P95_SHIFT, exact for n up to 4096
  localparam int unsigned P95_RECIP  = 3277;
  localparam int unsigned P95_RECIP_W = 12;
  localparam int unsigned P95_SHIFT  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP = 1'b0,
    CFG_WINDOW = 1'b1
  } wfts_cfg_e;

  typedef struct packed {
    logic measure;
    logic store;
  } wfts_cmd_flags_t;

endpackage
`default_nettype wire

/* rtl/core/wfts_front.sv */
// front end: boundary latch, duration, frame numbering, warmup and window decode
`default_nettype none
module wfts_front import wfts_pkg::*; #(
  parameter int unsigned DEPTH          = 256,
  parameter int unsigned DURATION_WIDTH = 32,
  parameter int unsigned CW             = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                      accept_i,
  input  wire logic [TS_W-1:0]           timestamp_i,
  output wfts_cmd_flags_t                flags_o,
  output logic [CW-1:0]                  win_o,
  output logic [DURATION_WIDTH-1:0]      dur_o
);

  logic                have_q, have_d;
  logic [TS_W-1:0]     last_q, last_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [WARMUP_W-1:0] warmup_q, warmup_d;
  logic [WINDOW_W-1:0] window_q, window_d;
  logic [TS_W-1:0]     diff;

  always_comb begin
    diff = timestamp_i - last_q;
    if ((diff >> DURATION_WIDTH) != '0) begin
      dur_o = '1;
    end else begin
      dur_o = DURATION_WIDTH'(diff);
    end
    if (window_q == '0 || 32'(window_q) > 32'(DEPTH)) begin
      win_o = CW'(DEPTH);
    end else begin
      win_o = CW'(window_q);
    end
    flags_o.measure = have_q;
    flags_o.store   = have_q && (frame_q >= FRAME_W'(warmup_q));
  end

  always_comb begin
    have_d   = have_q;
    last_d   = last_q;
    frame_d  = frame_q;
    warmup_d = warmup_q;
    window_d = window_q;
    if (accept_i) begin
      have_d = 1'b1;
      last_d = timestamp_i;
      if (have_q && frame_q != '1) begin
        frame_d = frame_q + 1'b1;
      end
    end
    if (cfg_we_i) begin
      case (wfts_cfg_e'(cfg_idx_i))
        CFG_WARMUP: warmup_d = WARMUP_W'(cfg_data_i);
        CFG_WINDOW: window_d = WINDOW_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      last_q   <= '0;
      frame_q  <= '0;
      warmup_q <= '0;
      window_q <= '0;
    end else begin
      have_q   <= have_d;
      last_q   <= last_d;
      frame_q  <= frame_d;
      warmup_q <= warmup_d;
      window_q <= window_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wfts_cmd_fifo.sv */
// two entry command queue between front and back
`default_nettype none
module wfts_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= !wr_q;
      end
      if (pop_i && !empty_o) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wfts_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module wfts_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q, den_q;
  logic [NW-1:0]    q_q;
  logic [DW:0]      sh;
  logic             ge;

  assign sh     = {rem_q, q_q[NW-1]};
  assign ge     = sh >= {1'b0, den_q};
  assign quo_o  = q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      q_q   <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(sh - {1'b0, den_q}) : DW'(sh);
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && !start_i && cnt_q == CNT_W'(NW - 1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wfts_back.sv */
// back end: duration ring, window walk with radix selection, mean and result slot
`default_nettype none
module wfts_back import wfts_pkg::*; #(
  parameter int unsigned DEPTH          = 256,
  parameter int unsigned DURATION_WIDTH = 32,
  parameter int unsigned CW             = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_empty_i,
  output logic                           cmd_pop_o,
  input  wfts_cmd_flags_t                flags_i,
  input  wire logic [CW-1:0]             win_i,
  input  wire logic [DURATION_WIDTH-1:0] dur_i,
  input  wire logic                      pop_i,
  output logic                           empty_o,
  output logic [COUNT_W-1:0]             sample_count_o,
  output logic [TICKS_W-1:0]             mean_ticks_o,
  output logic [MEDIAN_W-1:0]            median_half_ticks_o,
  output logic [TICKS_W-1:0]             p95_ticks_o,
  output logic [TICKS_W-1:0]             min_ticks_o,
  output logic [TICKS_W-1:0]             max_ticks_o
);

  localparam int unsigned DW   = DURATION_WIDTH;
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned SUMW = DW + CW;
  localparam int unsigned MW   = CW + P95_RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_PASS, S_ENDP, S_DIV, S_OUT
  } state_e;

  state_e          state_q;
  logic [DW-1:0]   ring [DEPTH];
  logic [PW-1:0]   wp_q, rs_q, rp_q;
  logic [CW-1:0]   fill_q, iss_q, rcv_q;
  logic            rd_vld_q;
  logic [DW-1:0]   rd_data_q;
  logic [DW-1:0]   cur_q, hi_q, min_q, max_q;
  logic [DW-1:0]   pre_q [3];
  logic [CW-1:0]   rk_q [3];
  logic [CW-1:0]   cnt_q [3];
  logic            first_q, div_start_q, div_done;
  logic [SUMW-1:0] sum_q, quo;
  logic [TICKS_W-1:0] mean_q;
  logic            out_full_q;
  logic            ring_we, ring_re;
  logic [CW-1:0]   fill_inc, fill_new;
  logic [CW:0]     rs_wide;
  logic [MW-1:0]   twentieth;

  assign empty_o   = !out_full_q;
  assign cmd_pop_o = state_q == S_IDLE && !cmd_empty_i;
  assign ring_we   = cmd_pop_o && flags_i.store;
  assign ring_re   = state_q == S_PASS && iss_q != fill_q;

  always_comb begin
    fill_inc = (flags_i.store && fill_q != CW'(DEPTH)) ? fill_q + 1'b1 : fill_q;
    fill_new = (flags_i.measure && fill_inc > win_i) ? win_i : fill_inc;
    rs_wide  = ((CW+1)'(wp_q) >= (CW+1)'(fill_q)) ? (CW+1)'(wp_q) - (CW+1)'(fill_q)
             : (CW+1)'(wp_q) + (CW+1)'(DEPTH) - (CW+1)'(fill_q);
    twentieth = (MW'(fill_q) * MW'(P95_RECIP)) >> P95_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[wp_q] <= dur_i;
    end
    if (ring_re) begin
      rd_data_q <= ring[rp_q];
    end
  end

  wfts_div #(.NW(SUMW), .DW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (sum_q),
    .den_i   (fill_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      rs_q        <= '0;
      rp_q        <= '0;
      iss_q       <= '0;
      rcv_q       <= '0;
      rd_vld_q    <= 1'b0;
      cur_q       <= '0;
      hi_q        <= '0;
      min_q       <= '0;
      max_q       <= '0;
      first_q     <= 1'b0;
      div_start_q <= 1'b0;
      sum_q       <= '0;
      mean_q      <= '0;
      out_full_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pre_q[k] <= '0;
        rk_q[k]  <= '0;
        cnt_q[k] <= '0;
      end
      sample_count_o      <= '0;
      mean_ticks_o        <= '0;
      median_half_ticks_o <= '0;
      p95_ticks_o         <= '0;
      min_ticks_o         <= '0;
      max_ticks_o         <= '0;
    end else begin
      div_start_q <= state_q == S_ENDP && cur_q[0];
      rd_vld_q    <= ring_re;
      if (pop_i && out_full_q) begin
        out_full_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            if (flags_i.store) begin
              wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
            end
            fill_q  <= fill_new;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          for (int k = 0; k < 3; k++) begin
            pre_q[k] <= '0;
            cnt_q[k] <= '0;
          end
          rk_q[0] <= (fill_q - 1'b1) >> 1;
          rk_q[1] <= fill_q >> 1;
          rk_q[2] <= fill_q - CW'(twentieth) - 1'b1;
          rs_q    <= PW'(rs_wide);
          rp_q    <= PW'(rs_wide);
          iss_q   <= '0;
          rcv_q   <= '0;
          cur_q   <= {1'b1, {(DW-1){1'b0}}};
          hi_q    <= '0;
          sum_q   <= '0;
          min_q   <= (fill_q == '0) ? '0 : '1;
          max_q   <= '0;
          first_q <= 1'b1;
          if (fill_q == '0) begin
            mean_q  <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_PASS;
          end
        end
        S_PASS: begin
          if (ring_re) begin
            iss_q <= iss_q + 1'b1;
            rp_q  <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
          end
          if (rd_vld_q) begin
            rcv_q <= rcv_q + 1'b1;
            for (int k = 0; k < 3; k++) begin
              if (((rd_data_q ^ pre_q[k]) & hi_q) == '0 && (rd_data_q & cur_q) == '0) begin
                cnt_q[k] <= cnt_q[k] + 1'b1;
              end
            end
            if (first_q) begin
              sum_q <= sum_q + SUMW'(rd_data_q);
              if (rd_data_q < min_q) min_q <= rd_data_q;
              if (rd_data_q > max_q) max_q <= rd_data_q;
            end
            if (rcv_q + 1'b1 == fill_q) begin
              state_q <= S_ENDP;
            end
          end
        end
        S_ENDP: begin
          for (int k = 0; k < 3; k++) begin
            if (rk_q[k] >= cnt_q[k]) begin
              pre_q[k] <= pre_q[k] | cur_q;
              rk_q[k]  <= rk_q[k] - cnt_q[k];
            end
            cnt_q[k] <= '0;
          end
          first_q <= 1'b0;
          if (cur_q[0]) begin
            state_q     <= S_DIV;
          end else begin
            cur_q   <= cur_q >> 1;
            hi_q    <= hi_q | cur_q;
            rp_q    <= rs_q;
            iss_q   <= '0;
            rcv_q   <= '0;
            state_q <= S_PASS;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean_q  <= TICKS_W'(quo);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_full_q) begin
            out_full_q          <= 1'b1;
            sample_count_o      <= COUNT_W'(fill_q);
            mean_ticks_o        <= mean_q;
            median_half_ticks_o <= MEDIAN_W'((DW+1)'(pre_q[0]) + (DW+1)'(pre_q[1]));
            p95_ticks_o         <= TICKS_W'(pre_q[2]);
            min_ticks_o         <= TICKS_W'(min_q);
            max_ticks_o         <= TICKS_W'(max_q);
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && !pop_i |=> out_full_q && $stable(mean_ticks_o))
    else $error("result slot changed while waiting");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(DEPTH))
    else $error("fill exceeds depth");
  a_pass_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PASS |-> fill_q != '0)
    else $error("walk over empty window");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule
`default_nettype wire

/* rtl/core/windowed_frame_time_statistics.sv */
// top level of the windowed frame time statistics block
// Each pushed timestamp yields one result: count, floor mean, median in half ticks,
// nearest-rank 95th percentile, min and max over the last window of stored frame
// durations. The window is walked once per duration bit through the single read port
// of the duration ring, then a bit-serial divider forms the mean. A two entry command
// queue lets pushes continue while a window is walked.
`default_nettype none
module windowed_frame_time_statistics import wfts_pkg::*; #(
  parameter int unsigned DEPTH          = 256,
  parameter int unsigned DURATION_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [TS_W-1:0]       timestamp_i,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [COUNT_W-1:0]         sample_count_o,
  output logic [TICKS_W-1:0]         mean_ticks_o,
  output logic [MEDIAN_W-1:0]        median_half_ticks_o,
  output logic [TICKS_W-1:0]         p95_ticks_o,
  output logic [TICKS_W-1:0]         min_ticks_o,
  output logic [TICKS_W-1:0]         max_ticks_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMDW = 2 + CW + DURATION_WIDTH;

  wfts_cmd_flags_t             f_flags, b_flags;
  logic [CW-1:0]               f_win, b_win;
  logic [DURATION_WIDTH-1:0]   f_dur, b_dur;
  logic                        accept, cmd_empty, cmd_pop;

  assign accept = push && !full;

  wfts_front #(.DEPTH(DEPTH), .DURATION_WIDTH(DURATION_WIDTH), .CW(CW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .timestamp_i (timestamp_i),
    .flags_o     (f_flags),
    .win_o       (f_win),
    .dur_o       (f_dur)
  );

  wfts_cmd_fifo #(.WIDTH(CMDW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_flags, f_win, f_dur}),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  ({b_flags, b_win, b_dur})
  );

  wfts_back #(.DEPTH(DEPTH), .DURATION_WIDTH(DURATION_WIDTH), .CW(CW)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_empty_i         (cmd_empty),
    .cmd_pop_o           (cmd_pop),
    .flags_i             (b_flags),
    .win_i               (b_win),
    .dur_i               (b_dur),
    .pop_i               (pop),
    .empty_o             (empty),
    .sample_count_o      (sample_count_o),
    .mean_ticks_o        (mean_ticks_o),
    .median_half_ticks_o (median_half_ticks_o),
    .p95_ticks_o         (p95_ticks_o),
    .min_ticks_o         (min_ticks_o),
    .max_ticks_o         (max_ticks_o)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the windowed frame time statistics block
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import wfts_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned MAX_CYCLES = 60000000;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [TICKS_W-1:0]  mean;
    logic [MEDIAN_W-1:0] median;
    logic [TICKS_W-1:0]  p95;
    logic [TICKS_W-1:0]  min;
    logic [TICKS_W-1:0]  max;
  } frame_stats_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_WARMUP;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [TS_W-1:0]       timestamp_i = '0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [COUNT_W-1:0]    sample_count_o;
  logic [TICKS_W-1:0]    mean_ticks_o;
  logic [MEDIAN_W-1:0]   median_half_ticks_o;
  logic [TICKS_W-1:0]    p95_ticks_o;
  logic [TICKS_W-1:0]    min_ticks_o;
  logic [TICKS_W-1:0]    max_ticks_o;

  windowed_frame_time_statistics i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .timestamp_i, .pop, .empty,
    .sample_count_o, .mean_ticks_o, .median_half_ticks_o,
    .p95_ticks_o, .min_ticks_o, .max_ticks_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  bit                 latched;
  logic [TS_W-1:0]    prev_ts;
  logic [FRAME_W-1:0] frame_num = '0;
  logic [31:0]        durations[DEPTH];
  int unsigned        wr_ptr;
  int unsigned        fill;
  int unsigned        warmup;
  int unsigned        window;

  frame_stats_t expected_stats[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           hold_off;
  bit           burst_mode;
  logic [TS_W-1:0] now_ts;

  function automatic frame_stats_t window_stats();
    frame_stats_t   s;
    logic [31:0]    srt[];
    logic [63:0]    sum;
    int unsigned    rank;
    s = '0;
    sum = '0;
    if (fill == 0) return s;
    srt = new[fill];
    for (int unsigned i = 0; i < fill; i++) begin
      srt[i] = durations[(wr_ptr + DEPTH - fill + i) % DEPTH];
      sum += durations[(wr_ptr + DEPTH - fill + i) % DEPTH];
    end
    srt.sort();
    s.count = COUNT_W'(fill);
    s.mean = TICKS_W'(sum / fill);
    if (fill % 2) s.median = {1'b0, srt[fill/2]} << 1;
    else s.median = {1'b0, srt[fill/2-1]} + {1'b0, srt[fill/2]};
    rank = (fill * 95 + 99) / 100;
    s.p95 = srt[rank-1];
    s.min = srt[0];
    s.max = srt[fill-1];
    return s;
  endfunction

  function automatic void predict_boundary(logic [TS_W-1:0] ts);
    logic [TS_W-1:0] dur;
    logic [FRAME_W-1:0] frame;
    int unsigned w;
    if (!latched) begin
      latched = 1'b1;
      prev_ts = ts;
    end else begin
      dur = ts - prev_ts;
      frame = frame_num;
      w = (window == 0 || window > DEPTH) ? DEPTH : window;
      if (frame_num != '1) frame_num++;
      prev_ts = ts;
      if (frame >= warmup) begin
        durations[wr_ptr] = (dur > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : dur[31:0];
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill < DEPTH) fill++;
      end
      if (fill > w) fill = w;
    end
    expected_stats.insert(expected_stats.size(), window_stats());
  endfunction

  task automatic send_boundary(logic [TS_W-1:0] ts);
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    push = 1'b1;
    timestamp_i = ts;
    do @(posedge clk_i); while (full);
    predict_boundary(ts);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic advance(logic [TS_W-1:0] delta);
    now_ts = now_ts + delta;
    send_boundary(now_ts);
  endtask

  task automatic drain();
    while (expected_stats.size() != 0) @(negedge clk_i);
    repeat (DEPTH * 40) @(negedge clk_i);
  endtask

  task automatic write_reg(wfts_cfg_e idx, int unsigned value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_WARMUP) warmup = value & 16'hFFFF;
    else window = value & 9'h1FF;
  endtask

  function automatic logic [TS_W-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0: return TS_W'({$urandom, $urandom});
      1: return 48'hFFFF_FFFF + TS_W'($urandom_range(0, 3));
      2: return TS_W'($urandom_range(0, 2));
      default: return TS_W'($urandom_range(1000, 40000));
    endcase
  endfunction

  task automatic test_directed();
    now_ts = 48'hFFFF_FFFF_FFF0;
    send_boundary(now_ts);
    advance(48'h20);
    advance(48'h0);
    advance(48'hFFFF_FFFF);
    advance(48'h1_0000_0000);
    advance(48'hFFFF_FFFF_FFFF);
    advance(48'h5555_5555_5555);
    advance(48'hAAAA_AAAA_AAAA);
    advance(48'h1);
    advance(48'h7FFF_FFFF);
    advance(48'h8000_0000);
    drain();
  endtask

  task automatic test_warmup();
    write_reg(CFG_WARMUP, 16'hFFFF);
    write_reg(CFG_WINDOW, 3);
    repeat (5) advance(rand_delta());
    drain();
    write_reg(CFG_WARMUP, 0);
    repeat (8) advance(rand_delta());
    drain();
  endtask

  task automatic test_window_settings();
    int unsigned settings[6] = '{1, 2, 256, 0, 511, 257};
    foreach (settings[k]) begin
      write_reg(CFG_WINDOW, settings[k]);
      repeat (k < 2 ? 6 : 40) advance(rand_delta());
      drain();
    end
    write_reg(CFG_WINDOW, 0);
    repeat (260) advance(rand_delta());
    drain();
    write_reg(CFG_WINDOW, 5);
    write_reg(CFG_WARMUP, 16'hFFFF);
    advance(rand_delta());
    drain();
    write_reg(CFG_WARMUP, 0);
  endtask

  task automatic test_random();
    burst_mode = 1'b1;
    for (int unsigned ph = 0; ph < 4; ph++) begin
      write_reg(CFG_WINDOW, $urandom_range(1, 40));
      write_reg(CFG_WARMUP, $urandom_range(0, 300));
      repeat (30) advance(rand_delta());
      drain();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WINDOW, 8);
    hold_off = 1'b1;
    repeat (12) advance(TS_W'($urandom_range(1, 500)));
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_warmup();
    test_backpressure();
    test_window_settings();
    test_random();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver stall pattern and long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (cycles % 512 < 128) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    frame_stats_t exp_s;
    frame_stats_t got;
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && pop && !empty) begin
      got = '{sample_count_o, mean_ticks_o, median_half_ticks_o,
              p95_ticks_o, min_ticks_o, max_ticks_o};
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", got);
      end else begin
        exp_s = expected_stats.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp_s, got);
        end
      end
    end
  end
endmodule
`default_nettype wire
